>>> hw/rtl/ewdh_pkg.sv
// Package: facing codes and tangent constants for the eight-way direction quantizer.
`timescale 1ns / 1ps

package ewdh_pkg;

  // Keypad facing codes, y grows downward
  localparam logic [3:0] DIR_DL = 4'd1;
  localparam logic [3:0] DIR_D  = 4'd2;
  localparam logic [3:0] DIR_DR = 4'd3;
  localparam logic [3:0] DIR_W  = 4'd4;
  localparam logic [3:0] DIR_E  = 4'd6;
  localparam logic [3:0] DIR_UL = 4'd7;
  localparam logic [3:0] DIR_U  = 4'd8;
  localparam logic [3:0] DIR_UR = 4'd9;

  localparam int NUM_THR = 6;

  // tan of 15, 22.5, 30, 60, 67.5, 75 degrees times 2^32
  localparam logic [63:0] TAN_Q32 [NUM_THR] = '{
    64'd1150833018, 64'd1779033704, 64'd2479700525,
    64'd7439101574, 64'd10368968296, 64'd16029036166
  };

  // Round-to-nearest tangent with frac fraction bits
  function automatic logic [63:0] tan_fixed(int idx, int frac);
    logic [63:0] q;
    q = TAN_Q32[idx];
    return (q + (64'd1 << (31 - frac))) >> (32 - frac);
  endfunction

  // Pipeline flags that travel with each request
  typedef struct packed {
    logic       dx_neg;
    logic       dy_neg;
    logic       zero;
    logic [3:0] prev;
  } ewdh_flags_t;

endpackage

>>> hw/rtl/eight_way_direction_hysteresis.sv
// Top level: pipelined eight-way facing quantizer with band hysteresis.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+---------------------------
//  input    | in_from_x/y, in_to_x/y, in_prev_direction     | accepted when start & !busy
//  result   | out_direction                                 | out_valid strobe, one cycle
//
// Five register stages: difference, magnitude, tangent products, threshold
// compares, band decode. One request per cycle; out_valid rises when a request
// leaves the band decode register, and the result is taken on that strobe.
// The six constant-coefficient multipliers in stage 3 set the stage depth.
// busy is high only while rst_n is low; synchronous reset clears all valid bits.
// The receiver cannot stall, so results leave on the strobe as they are done.
`timescale 1ns / 1ps

module eight_way_direction_hysteresis
  import ewdh_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int TAN_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_from_x,
  input  logic signed [COORD_BITS-1:0] in_from_y,
  input  logic signed [COORD_BITS-1:0] in_to_x,
  input  logic signed [COORD_BITS-1:0] in_to_y,
  input  logic [3:0]                   in_prev_direction,
  output logic                         out_valid,
  output logic [3:0]                   out_direction
);

  localparam int DW = COORD_BITS + 1;           // exact difference
  localparam int NW = COORD_BITS + TAN_FRAC_BITS; // ay scaled
  localparam int TW = TAN_FRAC_BITS + 2;        // tan(75) < 4
  localparam int PW = COORD_BITS + TW;

  assign busy = ~rst_n;

  // ---------------- stage 1: differences ----------------
  logic                 v1_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic [3:0]           prev1_r;

  // ---------------- stage 2: magnitudes ----------------
  logic                  v2_r;
  logic [COORD_BITS-1:0] ax_r;
  logic [NW-1:0]         num2_r;
  ewdh_flags_t           fl2_r, fl2_nxt;
  // |difference| never exceeds 2^COORD_BITS - 1
  logic [COORD_BITS-1:0] ax_nxt, ay_nxt;

  always_comb begin
    ax_nxt          = dx_r[DW-1] ? COORD_BITS'(-dx_r) : COORD_BITS'(dx_r);
    ay_nxt          = dy_r[DW-1] ? COORD_BITS'(-dy_r) : COORD_BITS'(dy_r);
    fl2_nxt.dx_neg  = dx_r[DW-1];
    fl2_nxt.dy_neg  = dy_r[DW-1];
    fl2_nxt.zero    = (dx_r == '0) && (dy_r == '0);
    fl2_nxt.prev    = prev1_r;
  end

  // ---------------- stage 3: tangent products ----------------
  logic              v3_r;
  logic [PW-1:0]     prod_r [NUM_THR];
  logic [NW-1:0]     num3_r;
  ewdh_flags_t       fl3_r;

  for (genvar gi = 0; gi < NUM_THR; gi++) begin : g_mul
    localparam logic [TW-1:0] TanFix = TW'(tan_fixed(gi, TAN_FRAC_BITS));
    always_ff @(posedge clk) begin
      prod_r[gi] <= PW'(TanFix) * PW'(ax_r);
    end
  end

  // ---------------- stage 4: threshold compares ----------------
  logic               v4_r;
  logic [NUM_THR-1:0] cmp_r, cmp_nxt;
  ewdh_flags_t        fl4_r;

  always_comb begin
    for (int i = 0; i < NUM_THR; i++) begin
      // left half: angle is 180 - a, ties go to the larger angle
      cmp_nxt[i] = fl3_r.dx_neg ? (PW'(num3_r) <= prod_r[i]) : (PW'(num3_r) >= prod_r[i]);
    end
  end

  // ---------------- stage 5: band decode ----------------
  logic       out_valid_r;
  logic [3:0] out_direction_r, dir_nxt;
  logic [3:0] k;
  logic [3:0] lo, hi;
  logic [1:0] rem;
  logic [3:0] d_diag, d_vert, d_back;

  always_comb begin
    k      = 4'($countones(cmp_r)) + (fl4_r.dx_neg ? 4'd6 : 4'd0);
    d_diag = fl4_r.dy_neg ? DIR_UR : DIR_DR;
    d_vert = fl4_r.dy_neg ? DIR_U  : DIR_D;
    d_back = fl4_r.dy_neg ? DIR_UL : DIR_DL;
    lo     = DIR_E;
    hi     = DIR_E;
    rem    = 2'd0;
    case (k)
      4'd0:    begin lo = DIR_E;  hi = DIR_E;  rem = 2'd0; end
      4'd1:    begin lo = DIR_E;  hi = d_diag; rem = 2'd1; end
      4'd2:    begin lo = DIR_E;  hi = d_diag; rem = 2'd2; end
      4'd3:    begin lo = d_diag; hi = d_diag; rem = 2'd0; end
      4'd4:    begin lo = d_diag; hi = d_vert; rem = 2'd1; end
      4'd5:    begin lo = d_diag; hi = d_vert; rem = 2'd2; end
      4'd6:    begin lo = d_vert; hi = d_vert; rem = 2'd0; end
      4'd7:    begin lo = d_vert; hi = d_back; rem = 2'd1; end
      4'd8:    begin lo = d_vert; hi = d_back; rem = 2'd2; end
      4'd9:    begin lo = d_back; hi = d_back; rem = 2'd0; end
      4'd10:   begin lo = d_back; hi = DIR_W;  rem = 2'd1; end
      4'd11:   begin lo = d_back; hi = DIR_W;  rem = 2'd2; end
      default: begin lo = DIR_W;  hi = DIR_W;  rem = 2'd0; end
    endcase
    if (fl4_r.zero) begin
      dir_nxt = DIR_E;
    end else if (rem == 2'd0) begin
      dir_nxt = lo;
    end else if (fl4_r.prev == lo || fl4_r.prev == hi) begin
      dir_nxt = fl4_r.prev;   // hysteresis: keep a neighboring facing
    end else if (rem == 2'd1) begin
      dir_nxt = lo;
    end else begin
      dir_nxt = hi;
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    dx_r            <= DW'(in_to_x) - DW'(in_from_x);
    dy_r            <= DW'(in_to_y) - DW'(in_from_y);
    prev1_r         <= in_prev_direction;
    ax_r            <= ax_nxt;
    num2_r          <= {ay_nxt, {TAN_FRAC_BITS{1'b0}}};
    fl2_r           <= fl2_nxt;
    num3_r          <= num2_r;
    fl3_r           <= fl2_r;
    cmp_r           <= cmp_nxt;
    fl4_r           <= fl3_r;
    out_direction_r <= dir_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_direction = out_direction_r;

endmodule
